/* hdl/bpq_pkg.sv */
// Shared types, constants and pointer helpers for the bounded priority queue.
// Used by every module of the queue; depends on nothing else.
package bpq_pkg;

   localparam int DEPTH          = 16;
   localparam int PRIORITY_BITS  = 8;
   localparam int PAYLOAD_BITS   = 32;
   localparam int CAP_BITS       = 5;
   localparam int COUNT_OUT_BITS = 5;
   localparam int PTR_BITS       = $clog2(DEPTH);
   localparam int COUNT_BITS     = $clog2(DEPTH + 1);
   localparam int SUM_BITS       = COUNT_BITS + 1;
   localparam int CMP_BITS       = (CAP_BITS > COUNT_BITS) ? CAP_BITS : COUNT_BITS;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [1:0] ST_ADDED   = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_REMOVED = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   typedef logic [PTR_BITS-1:0]   ptr_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [PAYLOAD_BITS-1:0]  payload;
   } entry_type;

   typedef struct packed {
      logic      rd_en;
      ptr_type   rd_addr;
      logic      wr_en;
      ptr_type   wr_addr;
      entry_type wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [PRIORITY_BITS-1:0]  prio;
      logic [PAYLOAD_BITS-1:0]   payload;
      logic [COUNT_OUT_BITS-1:0] count_out;
   } result_type;

   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_type r;
      r = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
      return r;
   endfunction

   function automatic ptr_type ptr_dec(input ptr_type p);
      ptr_type r;
      r = (p == '0) ? PTR_BITS'(DEPTH - 1) : p - PTR_BITS'(1);
      return r;
   endfunction

   function automatic ptr_type ptr_add(input ptr_type p, input count_type n);
      logic [SUM_BITS-1:0] s;
      s = SUM_BITS'(p) + SUM_BITS'(n);
      if (s >= SUM_BITS'(DEPTH)) begin
         s = s - SUM_BITS'(DEPTH);
      end
      return PTR_BITS'(s);
   endfunction

endpackage

/* hdl/bounded_priority_queue_core.sv */
// A rejected add or an empty remove goes straight to the done state; a remove first reads
// the head entry; an add runs the insert scan, which reads and rewrites one memory entry a
// cycle, moving aside each entry whose priority is not above the new one, then writes it.
// The done state waits while the output register is held. One item is in work at a time;
// the next request is taken in the cycle after the result enters the output register.
// Synchronous active-high reset empties the queue and sets the capacity register to 16;
// the entry memory is not cleared.
module bounded_priority_queue_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic [bpq_pkg::PRIORITY_BITS-1:0]     req_priority_req,
   input  logic [bpq_pkg::PAYLOAD_BITS-1:0]      req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic [bpq_pkg::PRIORITY_BITS-1:0]     rsp_out_priority,
   output logic [bpq_pkg::PAYLOAD_BITS-1:0]      rsp_out_payload,
   output logic [bpq_pkg::COUNT_OUT_BITS-1:0]    rsp_entry_count_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bpq_pkg::CAP_BITS-1:0]          csr_capacity_limit
);
   import bpq_pkg::*;

   logic [CAP_BITS-1:0] capacity_ff, capacity_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff;
   mem_req_type         mem_req;
   entry_type           rd_data;
   logic                out_free;
   logic                out_load;
   result_type          out_result;

   assign csr_ready    = 1'b1;
   assign capacity_in  = (csr_valid && csr_ready) ? csr_capacity_limit : capacity_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   bpq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   bpq_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_priority_req (req_priority_req),
      .req_payload      (req_payload),
      .capacity         (capacity_ff),
      .mem_req          (mem_req),
      .rd_data          (rd_data),
      .out_free         (out_free),
      .out_load         (out_load),
      .out_result       (out_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_ff <= out_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_out_priority    = rsp_ff.prio;
   assign rsp_out_payload     = rsp_ff.payload;
   assign rsp_entry_count_out = rsp_ff.count_out;

endmodule

/* hdl/bpq_store.sv */
// Entry memory of the priority queue: one write port, one registered read port.
// Depends on bpq_pkg for the entry and request types.
module bpq_store (
   input  logic                 clock,
   input  bpq_pkg::mem_req_type mem_req,
   output bpq_pkg::entry_type   rd_data
);
   import bpq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/bpq_ctrl.sv */
// Sequencer of the priority queue: ring pointers, entry count and the insert scan.
// Depends on bpq_pkg; drives the request port of bpq_store.
module bpq_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic [bpq_pkg::PRIORITY_BITS-1:0]    req_priority_req,
   input  logic [bpq_pkg::PAYLOAD_BITS-1:0]     req_payload,
   input  logic [bpq_pkg::CAP_BITS-1:0]         capacity,
   output bpq_pkg::mem_req_type                 mem_req,
   input  bpq_pkg::entry_type                   rd_data,
   input  logic                                 out_free,
   output logic                                 out_load,
   output bpq_pkg::result_type                  out_result
);
   import bpq_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INS_CMP  = 3'd1;
   localparam logic [2:0] S_INS_PUT  = 3'd2;
   localparam logic [2:0] S_REM_DATA = 3'd3;
   localparam logic [2:0] S_DONE     = 3'd4;

   logic [2:0] state_ff, state_in;
   ptr_type    head_ff, head_in;
   count_type  count_ff, count_in;
   ptr_type    scan_ptr_ff, scan_ptr_in;
   ptr_type    scan_left_ff, scan_left_in;
   entry_type  new_ff, new_in;
   result_type res_ff, res_in;

   logic [CMP_BITS-1:0] eff_cap;
   logic                full;
   count_type           count_inc;
   count_type           count_dec;
   ptr_type             next_ptr;

   always_comb begin
      eff_cap   = (CMP_BITS'(capacity) > CMP_BITS'(DEPTH)) ? CMP_BITS'(DEPTH)
                                                            : CMP_BITS'(capacity);
      full      = CMP_BITS'(count_ff) >= eff_cap;
      count_inc = count_ff + COUNT_BITS'(1);
      count_dec = count_ff - COUNT_BITS'(1);
      next_ptr  = ptr_inc(scan_ptr_ff);

      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      new_in       = new_ff;
      res_in       = res_ff;
      mem_req      = '0;
      req_ready    = (state_ff == S_IDLE);
      out_load     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               new_in.prio    = req_priority_req;
               new_in.payload = req_payload;
               if (req_operation == OP_ADD) begin
                  if (full) begin
                     res_in   = '{ST_FULL, '0, '0, COUNT_OUT_BITS'(count_ff)};
                     state_in = S_DONE;
                  end else if (count_ff == '0) begin
                     scan_ptr_in = head_ff;
                     state_in    = S_INS_PUT;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = ptr_add(head_ff, count_dec);
                     scan_ptr_in     = ptr_add(head_ff, count_dec);
                     scan_left_in    = PTR_BITS'(count_dec);
                     state_in        = S_INS_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in   = '{ST_EMPTY, '0, '0, COUNT_OUT_BITS'(count_ff)};
                     state_in = S_DONE;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = head_ff;
                     state_in        = S_REM_DATA;
                  end
               end
            end
         end
         S_INS_CMP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = next_ptr;
            if (rd_data.prio > new_ff.prio) begin
               mem_req.wr_data = new_ff;
               count_in        = count_inc;
               res_in          = '{ST_ADDED, '0, '0, COUNT_OUT_BITS'(count_inc)};
               state_in        = S_DONE;
            end else begin
               mem_req.wr_data = rd_data;
               if (scan_left_ff == '0) begin
                  state_in = S_INS_PUT;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = ptr_dec(scan_ptr_ff);
                  scan_ptr_in     = ptr_dec(scan_ptr_ff);
                  scan_left_in    = scan_left_ff - PTR_BITS'(1);
               end
            end
         end
         S_INS_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = scan_ptr_ff;
            mem_req.wr_data = new_ff;
            count_in        = count_inc;
            res_in          = '{ST_ADDED, '0, '0, COUNT_OUT_BITS'(count_inc)};
            state_in        = S_DONE;
         end
         S_REM_DATA: begin
            res_in   = '{ST_REMOVED, rd_data.prio, rd_data.payload,
                         COUNT_OUT_BITS'(count_dec)};
            head_in  = ptr_inc(head_ff);
            count_in = count_dec;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      scan_ptr_ff  <= scan_ptr_in;
      scan_left_ff <= scan_left_in;
      new_ff       <= new_in;
      res_ff       <= res_in;
   end

endmodule

/* hdl/bpq_checker.sv */
// Port-level checks of the priority queue over time, bound to the top level.
// Depends on bpq_pkg and on the ports of bounded_priority_queue_core.
module bpq_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [1:0]                            rsp_status,
   input logic [bpq_pkg::PRIORITY_BITS-1:0]     rsp_out_priority,
   input logic [bpq_pkg::PAYLOAD_BITS-1:0]      rsp_out_payload,
   input logic [bpq_pkg::COUNT_OUT_BITS-1:0]    rsp_entry_count_out
);
   import bpq_pkg::*;

   // A stalled result transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_priority) && $stable(rsp_out_payload)
         && $stable(rsp_entry_count_out))
      else $error("result transaction changed while stalled");

   // Only a removed entry carries priority and payload.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_REMOVED |->
         rsp_out_priority == '0 && rsp_out_payload == '0)
      else $error("nonzero data on a result without a removed entry");

   // An empty remove reports an empty queue.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count_out == '0)
      else $error("empty status with nonzero entry count");

   // An accepted request is never followed by another accept in the next cycle.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an item is in work");

endmodule

bind bounded_priority_queue_core bpq_checker u_bpq_checker (.*);
